/* src/mbc_pkg.sv */
// ============================================================================
// mbc_pkg: shared types and constants for masked bitvector compaction
// Word widths, support limits, queue sizing and the item structs that move
// between the front stage, the queue and the back stage.
// ============================================================================
`default_nettype none

package mbc_pkg;

    localparam int WORD_W    = 64;
    localparam int SHIFT_W   = 6;   // bit index inside a word
    localparam int CNT_W     = 7;   // 0..64
    localparam int SUP_W     = 17;
    localparam logic [SUP_W-1:0] SUPPORT_MAX = 17'd65536;
    localparam logic [CNT_W-1:0] FULL_BITS   = 7'd64;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // Front stage output: compressed bits plus counts.
    typedef struct packed {
        logic [WORD_W-1:0] comp;     // selected bits, packed from bit 0
        logic [CNT_W-1:0]  bit_cnt;  // popcount(mask)
        logic [CNT_W-1:0]  sel_cnt;  // popcount(data & mask)
        logic              last;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_push_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_head_t;

    typedef struct packed {
        logic [WORD_W-1:0] packed_word;
        logic [CNT_W-1:0]  valid_bits;
        logic              last_out;
        logic [SUP_W-1:0]  support;
        logic              frequent;
    } result_t;

    // Adder tree, six levels deep.
    function automatic logic [CNT_W-1:0] popcount64(input logic [WORD_W-1:0] v);
        logic [CNT_W-1:0] sum [WORD_W];
        for (int i = 0; i < WORD_W; i++)
        begin
            sum[i] = CNT_W'(v[i]);
        end
        for (int s = 1; s < WORD_W; s = s * 2)
        begin
            for (int i = 0; i < WORD_W; i += 2 * s)
            begin
                sum[i] = sum[i] + sum[i + s];
            end
        end
        return sum[0];
    endfunction

endpackage

`default_nettype wire

/* src/mbc_if.sv */
// ============================================================================
// mbc_if: valid/ready channels of masked bitvector compaction
// Input channel carries one data/mask word pair, output channel one result.
// ============================================================================
`default_nettype none

interface mbc_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_word;
    logic [63:0] mask_word;
    logic        last;

    modport source (output valid, output data_word, output mask_word, output last,
                    input ready);
    modport sink   (input valid, input data_word, input mask_word, input last,
                    output ready);
endinterface

interface mbc_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] packed_word;
    logic [6:0]  valid_bits;
    logic        last_out;
    logic [16:0] support;
    logic        frequent;

    modport source (output valid, output packed_word, output valid_bits,
                    output last_out, output support, output frequent,
                    input ready);
    modport sink   (input valid, input packed_word, input valid_bits,
                    input last_out, input support, input frequent,
                    output ready);
endinterface

`default_nettype wire

/* src/mbc_front.sv */
// ============================================================================
// mbc_front: accept word pairs and compress selected bits
// One register stage holds the word pair with per-bit shift amounts; a
// six-level shift network then packs the selected bits for the queue.
// ============================================================================
`default_nettype none

module mbc_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    mbc_in_if.sink              data_ch,
    input  wire logic           q_full,
    output mbc_pkg::q_push_t    q_push
);

    logic                                    s1_valid_reg;
    logic [mbc_pkg::WORD_W-1:0]              s1_sel_reg;   // data & mask
    logic [mbc_pkg::WORD_W-1:0]              s1_mask_reg;
    logic [mbc_pkg::SHIFT_W-1:0]             s1_amt_reg [mbc_pkg::WORD_W];
    logic [mbc_pkg::CNT_W-1:0]               s1_bit_cnt_reg;
    logic [mbc_pkg::CNT_W-1:0]               s1_sel_cnt_reg;
    logic                                    s1_last_reg;

    logic                                    accept;
    logic                                    push;
    logic [mbc_pkg::SHIFT_W-1:0]             amt_in [mbc_pkg::WORD_W];
    logic [mbc_pkg::WORD_W-1:0]              comp;

    assign push          = s1_valid_reg && !q_full;
    assign data_ch.ready = !s1_valid_reg || !q_full;
    assign accept        = data_ch.valid && data_ch.ready;

    // Shift amount of each bit = number of unselected positions below it.
    always_comb
    begin
        for (int i = 0; i < mbc_pkg::WORD_W; i++)
        begin
            amt_in[i] = mbc_pkg::SHIFT_W'(
                mbc_pkg::popcount64(~data_ch.mask_word & ((64'd1 << i) - 64'd1)));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (data_ch.ready)
        begin
            s1_valid_reg <= data_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sel_reg     <= data_ch.data_word & data_ch.mask_word;
            s1_mask_reg    <= data_ch.mask_word;
            s1_amt_reg     <= amt_in;
            s1_bit_cnt_reg <= mbc_pkg::popcount64(data_ch.mask_word);
            s1_sel_cnt_reg <= mbc_pkg::popcount64(data_ch.data_word &
                                                  data_ch.mask_word);
            s1_last_reg    <= data_ch.last;
        end
    end

    // Compress network: bits move down by their shift amount, one power of
    // two per level, lowest first; moves never collide.
    always_comb
    begin
        logic [mbc_pkg::WORD_W-1:0]  lv_bit [mbc_pkg::SHIFT_W+1];
        logic [mbc_pkg::WORD_W-1:0]  lv_vld [mbc_pkg::SHIFT_W+1];
        logic [mbc_pkg::SHIFT_W-1:0] lv_amt [mbc_pkg::SHIFT_W+1][mbc_pkg::WORD_W];
        logic                        same;
        logic                        high;
        lv_bit[0] = s1_sel_reg;
        lv_vld[0] = s1_mask_reg;
        lv_amt[0] = s1_amt_reg;
        for (int k = 0; k < mbc_pkg::SHIFT_W; k++)
        begin
            for (int j = 0; j < mbc_pkg::WORD_W; j++)
            begin
                same = lv_vld[k][j] && !lv_amt[k][j][k];
                high = 1'b0;
                if (j + (1 << k) < mbc_pkg::WORD_W)
                begin
                    high = lv_vld[k][j + (1 << k)] && lv_amt[k][j + (1 << k)][k];
                end
                lv_vld[k+1][j] = same || high;
                if (high)
                begin
                    lv_bit[k+1][j] = lv_bit[k][j + (1 << k)];
                    lv_amt[k+1][j] = lv_amt[k][j + (1 << k)];
                end
                else
                begin
                    lv_bit[k+1][j] = same && lv_bit[k][j];
                    lv_amt[k+1][j] = lv_amt[k][j];
                end
            end
        end
        comp = lv_bit[mbc_pkg::SHIFT_W] & lv_vld[mbc_pkg::SHIFT_W];
    end

    always_comb
    begin
        q_push.valid         = push;
        q_push.entry.comp    = comp;
        q_push.entry.bit_cnt = s1_bit_cnt_reg;
        q_push.entry.sel_cnt = s1_sel_cnt_reg;
        q_push.entry.last    = s1_last_reg;
    end

endmodule

`default_nettype wire

/* src/mbc_fifo.sv */
// ============================================================================
// mbc_fifo: short queue between front and back stages
// Four entries of compressed words; head is read combinationally.
// ============================================================================
`default_nettype none

module mbc_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire mbc_pkg::q_push_t push,
    output logic                full,
    output mbc_pkg::q_head_t    head,
    input  wire logic           pop
);

    mbc_pkg::q_entry_t              mem_reg [mbc_pkg::QDEPTH];
    logic [mbc_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [mbc_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [mbc_pkg::QCNT_W-1:0]     count_reg;
    logic [mbc_pkg::QCNT_W-1:0]     count_next;
    logic                           do_push;
    logic                           do_pop;

    assign full       = (count_reg == mbc_pkg::QCNT_W'(mbc_pkg::QDEPTH));
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.entry;
        end
    end

endmodule

`default_nettype wire

/* src/mbc_back.sv */
// ============================================================================
// mbc_back: pack compressed words into 64-bit results
// Merges each queued word into the accumulator, counts support and emits up
// to two results per item through an output register and a pending slot.
// ============================================================================
`default_nettype none

module mbc_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire mbc_pkg::q_head_t           head,
    output logic                            pop,
    input  wire logic [mbc_pkg::SUP_W-1:0]  min_support,
    mbc_out_if.source                       result_ch
);

    logic [mbc_pkg::WORD_W-1:0]   acc_reg, acc_next;
    logic [mbc_pkg::SHIFT_W-1:0]  fill_reg, fill_next;
    logic [mbc_pkg::SUP_W-1:0]    support_reg, support_next;
    logic                         out_valid_reg, out_valid_next;
    mbc_pkg::result_t             out_reg, out_next;
    logic                         pend_valid_reg, pend_valid_next;
    mbc_pkg::result_t             pend_reg, pend_next;

    logic                         out_free;
    logic [2*mbc_pkg::WORD_W-1:0] wide;
    logic [mbc_pkg::CNT_W-1:0]    total;
    logic [mbc_pkg::SUP_W:0]      sup_sum;
    logic [mbc_pkg::SUP_W-1:0]    sup_new;
    logic                         frq;
    logic                         has1, has2;
    mbc_pkg::result_t             r1, r2;

    assign out_free = !out_valid_reg || result_ch.ready;
    assign pop      = head.valid && out_free && !pend_valid_reg;

    // Merge and result formation for the head item.
    always_comb
    begin
        wide    = {{mbc_pkg::WORD_W{1'b0}}, acc_reg} |
                  ({{mbc_pkg::WORD_W{1'b0}}, head.entry.comp} << fill_reg);
        total   = {1'b0, fill_reg} + head.entry.bit_cnt;
        sup_sum = {1'b0, support_reg} + (mbc_pkg::SUP_W+1)'(head.entry.sel_cnt);
        sup_new = (sup_sum > {1'b0, mbc_pkg::SUPPORT_MAX}) ? mbc_pkg::SUPPORT_MAX
                                                         : sup_sum[mbc_pkg::SUP_W-1:0];
        frq     = (sup_new >= min_support);

        has1 = 1'b0;
        has2 = 1'b0;
        r1   = '0;
        r2   = '0;
        acc_next     = acc_reg;
        fill_next    = fill_reg;
        support_next = support_reg;

        if (pop)
        begin
            support_next = sup_new;
            if (total[mbc_pkg::CNT_W-1])
            begin
                // A word filled up.
                has1 = 1'b1;
                r1.packed_word = wide[mbc_pkg::WORD_W-1:0];
                r1.valid_bits  = mbc_pkg::FULL_BITS;
                acc_next  = wide[2*mbc_pkg::WORD_W-1:mbc_pkg::WORD_W];
                fill_next = total[mbc_pkg::SHIFT_W-1:0];
                if (head.entry.last)
                begin
                    if (total[mbc_pkg::SHIFT_W-1:0] == '0)
                    begin
                        r1.last_out = 1'b1;
                        r1.support  = sup_new;
                        r1.frequent = frq;
                    end
                    else
                    begin
                        has2 = 1'b1;
                        r2.packed_word = wide[2*mbc_pkg::WORD_W-1:mbc_pkg::WORD_W];
                        r2.valid_bits  = {1'b0, total[mbc_pkg::SHIFT_W-1:0]};
                        r2.last_out    = 1'b1;
                        r2.support     = sup_new;
                        r2.frequent    = frq;
                    end
                end
            end
            else
            begin
                acc_next  = wide[mbc_pkg::WORD_W-1:0];
                fill_next = total[mbc_pkg::SHIFT_W-1:0];
                if (head.entry.last)
                begin
                    // Partial (possibly empty) closing word.
                    has1 = 1'b1;
                    r1.packed_word = wide[mbc_pkg::WORD_W-1:0];
                    r1.valid_bits  = total;
                    r1.last_out    = 1'b1;
                    r1.support     = sup_new;
                    r1.frequent    = frq;
                end
            end
            if (head.entry.last)
            begin
                acc_next     = '0;
                fill_next    = '0;
                support_next = '0;
            end
        end
    end

    // Output register and pending slot.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (out_free)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_next        = pend_reg;
                pend_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = has1;
                out_next       = r1;
                if (has2)
                begin
                    pend_valid_next = 1'b1;
                    pend_next       = r2;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg        <= '0;
            fill_reg       <= '0;
            support_reg    <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg        <= acc_next;
            fill_reg       <= fill_next;
            support_reg    <= support_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

    assign result_ch.valid       = out_valid_reg;
    assign result_ch.packed_word = out_reg.packed_word;
    assign result_ch.valid_bits  = out_reg.valid_bits;
    assign result_ch.last_out    = out_reg.last_out;
    assign result_ch.support     = out_reg.support;
    assign result_ch.frequent    = out_reg.frequent;

    // A pending result always sits behind a shown one.
    a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> out_valid_reg)
        else $error("pending result without output result");

    // Only a closing result may carry a partial word or support.
    a_mid_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.last_out) |->
            (out_reg.valid_bits == mbc_pkg::FULL_BITS && out_reg.support == '0
             && !out_reg.frequent))
        else $error("non-final result is not a clean full word");

    // After a closing item is taken the running state is clear.
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.entry.last) |=> (fill_reg == '0 && support_reg == '0 &&
                                      acc_reg == '0))
        else $error("state not cleared after last item");

endmodule

`default_nettype wire

/* src/masked_bitvector_compaction.sv */
// ============================================================================
// masked_bitvector_compaction: bit extract and pack with support count
// Gathers data bits selected by a mask over a multiword vector, packs them
// into 64-bit words and reports the saturating support on the last result.
// ============================================================================
// Usage:
//   data_ch   : one data/mask word pair per item, last marks the final pair.
//   result_ch : packed 64-bit words; valid_bits gives the fill (64 when
//               full). The final result of a vector has last_out set and
//               carries support and frequent; earlier results carry zeros.
//   cfg_we / cfg_wdata : write min_support (reset value 1) while idle.
// Timing:
//   One item per cycle while the queue and receiver keep up. An accepted item
//   is registered in the front stage, compressed into the four-entry queue
//   and merged by the back stage into the output register. An item yields
//   zero, one or two results; the output register moves one result per
//   cycle while the receiver is ready, and a second result waits in the
//   pending slot, during which the back stage pops no item.
// Stalls and reset:
//   A stalled receiver holds the result; the back stage stops popping, the
//   queue fills and data_ch.ready drops when the front register is blocked.
//   Reset clears the accumulator, fill count, support count, queue and
//   output valids, and sets min_support to 1.
// ============================================================================
`default_nettype none

module masked_bitvector_compaction (
    input  wire logic         clk,
    input  wire logic         rst_n,
    mbc_in_if.sink            data_ch,
    mbc_out_if.source         result_ch,
    input  wire logic         cfg_we,
    input  wire logic [16:0]  cfg_wdata
);

    logic [mbc_pkg::SUP_W-1:0] min_support_reg;
    mbc_pkg::q_push_t          q_push;
    mbc_pkg::q_head_t          q_head;
    logic                      q_full;
    logic                      q_pop;

    // Threshold register; the user must write it only between vectors, the block does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_support_reg <= mbc_pkg::SUP_W'(1);
        end
        else if (cfg_we)
        begin
            min_support_reg <= cfg_wdata;
        end
    end

    // Front: accept pairs, compress selected bits, count.
    mbc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .data_ch (data_ch),
        .q_full  (q_full),
        .q_push  (q_push)
    );

    // Decoupling queue.
    mbc_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .full  (q_full),
        .head  (q_head),
        .pop   (q_pop)
    );

    // Back: pack into words, track support, drive results.
    mbc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (q_head),
        .pop         (q_pop),
        .min_support (min_support_reg),
        .result_ch   (result_ch)
    );

endmodule

`default_nettype wire
